FILE: src/ffwrl_pkg.sv
`timescale 1ns / 1ps

package ffwrl_pkg;

   localparam int ACCT_W      = 6;
   localparam int ACCT_CODES  = 1 << ACCT_W;
   localparam int NOW_W       = 39;
   localparam int DATE_W      = 40;
   localparam int COUNT_W     = 16;
   localparam int WIN_W       = 32;
   localparam int AGE_DAYS_W  = 16;
   localparam int AGE_LIMIT_W = 33;
   localparam int CSR_IDX_W   = 3;
   localparam int CSR_DATA_W  = 32;

   localparam logic [AGE_LIMIT_W-1:0] SECS_PER_DAY = AGE_LIMIT_W'(86400);
   localparam logic [WIN_W-1:0]       WIN_RESET    = WIN_W'(3600);
   localparam logic [COUNT_W-1:0]     COUNT_MAX    = '1;

   localparam logic [CSR_IDX_W-1:0] CSR_ENABLE         = CSR_IDX_W'(0);
   localparam logic [CSR_IDX_W-1:0] CSR_SKIP_AUTOMATED = CSR_IDX_W'(1);
   localparam logic [CSR_IDX_W-1:0] CSR_MAX_AGE_DAYS   = CSR_IDX_W'(2);
   localparam logic [CSR_IDX_W-1:0] CSR_WINDOW_SECONDS = CSR_IDX_W'(3);
   localparam logic [CSR_IDX_W-1:0] CSR_MAX_PER_WINDOW = CSR_IDX_W'(4);

   typedef enum logic [2:0] {
      VERDICT_ADMITTED = 3'd0,
      VERDICT_DISABLED = 3'd1,
      VERDICT_STATE    = 3'd2,
      VERDICT_AUTO     = 3'd3,
      VERDICT_AGE      = 3'd4,
      VERDICT_RATE     = 3'd5
   } verdict_type;

   typedef struct packed {
      logic                   enable;
      logic                   skip_automated;
      logic [AGE_LIMIT_W-1:0] age_limit;      // max_age_days * 86400, zero = off
      logic [WIN_W-1:0]       window_seconds;
      logic [COUNT_W-1:0]     max_per_window;
   } cfg_type;

   typedef struct packed {
      logic [NOW_W-1:0]   start;
      logic [COUNT_W-1:0] count;
   } entry_type;

   localparam int ENTRY_W = $bits(entry_type);

endpackage

FILE: src/ffwrl_ram.sv
`timescale 1ns / 1ps

module ffwrl_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 64
) (
   input  logic                                  clock,
   input  logic                                  wr_en,
   input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] wr_addr,
   input  logic [WIDTH-1:0]                      wr_data,
   input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] rd_addr,
   output logic [WIDTH-1:0]                      rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem_ff[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

FILE: src/ffwrl_csr.sv
`timescale 1ns / 1ps

module ffwrl_csr (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                csr_valid,
   output logic                                csr_ready,
   input  logic [ffwrl_pkg::CSR_IDX_W-1:0]     csr_index,
   input  logic [ffwrl_pkg::CSR_DATA_W-1:0]    csr_data,
   output ffwrl_pkg::cfg_type                  cfg
);

   ffwrl_pkg::cfg_type cfg_ff;
   ffwrl_pkg::cfg_type cfg_in;

   always_comb begin
      cfg_in = cfg_ff;
      if (csr_valid) begin
         case (csr_index)
            ffwrl_pkg::CSR_ENABLE: begin
               cfg_in.enable = csr_data[0];
            end
            ffwrl_pkg::CSR_SKIP_AUTOMATED: begin
               cfg_in.skip_automated = csr_data[0];
            end
            ffwrl_pkg::CSR_MAX_AGE_DAYS: begin
               cfg_in.age_limit =
                  ffwrl_pkg::AGE_LIMIT_W'(csr_data[ffwrl_pkg::AGE_DAYS_W-1:0])
                  * ffwrl_pkg::SECS_PER_DAY;
            end
            ffwrl_pkg::CSR_WINDOW_SECONDS: begin
               cfg_in.window_seconds = csr_data[ffwrl_pkg::WIN_W-1:0];
            end
            ffwrl_pkg::CSR_MAX_PER_WINDOW: begin
               cfg_in.max_per_window = csr_data[ffwrl_pkg::COUNT_W-1:0];
            end
            default: begin
               cfg_in = cfg_ff;
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.enable         <= 1'b0;
         cfg_ff.skip_automated <= 1'b0;
         cfg_ff.age_limit      <= '0;
         cfg_ff.window_seconds <= ffwrl_pkg::WIN_RESET;
         cfg_ff.max_per_window <= '0;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   assign csr_ready = 1'b1;
   assign cfg       = cfg_ff;

endmodule

FILE: src/filtered_fixed_window_rate_limiter_unit.sv
`timescale 1ns / 1ps

// Message admission filter with a per-account fixed-window rate limiter. One
// request is taken per clock (start high while busy is low); its verdict
// appears on the rsp_ ports, marked by rsp_valid, after the request register
// (with the window table read) and the result register (decision and write
// back). Back-to-back requests on the same account are forwarded, so the rate
// stays at one request per cycle. The receiver cannot stall: every result is
// shown for one cycle only. After reset the window table is cleared one entry
// per cycle, so busy stays high until the sweep ends; configuration
// writes are taken during that time and always (csr_ready is tied high).
module filtered_fixed_window_rate_limiter_unit #(
   parameter int ACCOUNTS = 64
) (
   input  logic                                 clock,
   input  logic                                 reset,
   input  logic                                 start,
   output logic                                 busy,
   input  logic [ffwrl_pkg::ACCT_W-1:0]         req_account_index,
   input  logic [ffwrl_pkg::NOW_W-1:0]          req_now_seconds,
   input  logic signed [ffwrl_pkg::DATE_W-1:0]  req_msg_date,
   input  logic                                 req_seen,
   input  logic                                 req_deleted,
   input  logic                                 req_draft,
   input  logic                                 req_automated,
   output logic                                 rsp_valid,
   output logic                                 rsp_admitted,
   output logic [2:0]                           rsp_verdict,
   input  logic                                 csr_valid,
   output logic                                 csr_ready,
   input  logic [ffwrl_pkg::CSR_IDX_W-1:0]      csr_index,
   input  logic [ffwrl_pkg::CSR_DATA_W-1:0]     csr_data
);

   localparam int IDX_W = (ACCOUNTS > 1) ? $clog2(ACCOUNTS) : 1;
   localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(ACCOUNTS - 1);

   ffwrl_pkg::cfg_type cfg;

   ffwrl_csr u_csr (
      .clock     (clock),
      .reset     (reset),
      .csr_valid (csr_valid),
      .csr_ready (csr_ready),
      .csr_index (csr_index),
      .csr_data  (csr_data),
      .cfg       (cfg)
   );

   // account code to table entry (code modulo ACCOUNTS)
   logic [IDX_W-1:0] acct_map [ffwrl_pkg::ACCT_CODES];

   for (genvar g = 0; g < ffwrl_pkg::ACCT_CODES; g++) begin : g_map
      assign acct_map[g] = IDX_W'(g % ACCOUNTS);
   end

   logic accept;
   logic clr_ff, clr_in;
   logic [IDX_W-1:0] clr_addr_ff, clr_addr_in;

   logic                                s1_valid_ff;
   logic [IDX_W-1:0]                    s1_idx_ff;
   logic [ffwrl_pkg::NOW_W-1:0]         s1_now_ff;
   logic signed [ffwrl_pkg::DATE_W-1:0] s1_date_ff;
   logic                                s1_state_ff;
   logic                                s1_auto_ff;

   logic                 fwd_valid_ff, fwd_valid_in;
   logic [IDX_W-1:0]     fwd_idx_ff;
   ffwrl_pkg::entry_type fwd_entry_ff;

   logic                   rsp_valid_ff;
   logic                   rsp_admitted_ff;
   ffwrl_pkg::verdict_type rsp_verdict_ff, verdict_in;

   logic [ffwrl_pkg::ENTRY_W-1:0] rd_data;
   ffwrl_pkg::entry_type          entry_cur, entry_new;
   logic                          tbl_we;
   logic                          ram_we;
   logic [IDX_W-1:0]              ram_wr_addr;
   logic [ffwrl_pkg::ENTRY_W-1:0] ram_wr_data;

   logic signed [ffwrl_pkg::DATE_W:0]  age_diff;
   logic signed [ffwrl_pkg::NOW_W:0]   win_diff;
   logic                               undated, too_old, expired, restart, limited;
   logic [ffwrl_pkg::COUNT_W-1:0]      count_eff;

   assign accept = start & ~clr_ff;
   assign busy   = clr_ff;

   // clearing sweep after reset
   always_comb begin
      clr_in      = clr_ff;
      clr_addr_in = clr_addr_ff;
      if (clr_ff) begin
         clr_addr_in = clr_addr_ff + IDX_W'(1);
         if (clr_addr_ff == LAST_IDX) begin
            clr_in = 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         clr_ff      <= 1'b1;
         clr_addr_ff <= '0;
      end else begin
         clr_ff      <= clr_in;
         clr_addr_ff <= clr_addr_in;
      end
   end

   // request register
   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff <= 1'b0;
      end else begin
         s1_valid_ff <= accept;
      end
      s1_idx_ff   <= acct_map[req_account_index];
      s1_now_ff   <= req_now_seconds;
      s1_date_ff  <= req_msg_date;
      s1_state_ff <= req_seen | req_deleted | req_draft;
      s1_auto_ff  <= req_automated;
   end

   assign ram_we      = tbl_we | clr_ff;
   assign ram_wr_addr = clr_ff ? clr_addr_ff : s1_idx_ff;
   assign ram_wr_data = clr_ff ? '0 : entry_new;

   ffwrl_ram #(
      .WIDTH (ffwrl_pkg::ENTRY_W),
      .DEPTH (ACCOUNTS)
   ) u_table (
      .clock   (clock),
      .wr_en   (ram_we),
      .wr_addr (ram_wr_addr),
      .wr_data (ram_wr_data),
      .rd_addr (acct_map[req_account_index]),
      .rd_data (rd_data)
   );

   // entry written last cycle is not yet in the read data
   assign entry_cur = (fwd_valid_ff && (fwd_idx_ff == s1_idx_ff)) ?
                      fwd_entry_ff : ffwrl_pkg::entry_type'(rd_data);

   assign undated  = s1_date_ff[ffwrl_pkg::DATE_W-1] | (s1_date_ff == '0);
   assign age_diff = $signed({2'b00, s1_now_ff})
                     - $signed({s1_date_ff[ffwrl_pkg::DATE_W-1], s1_date_ff});
   assign too_old  = age_diff > $signed({8'b0, cfg.age_limit});

   assign win_diff = $signed({1'b0, s1_now_ff}) - $signed({1'b0, entry_cur.start});
   assign expired  = !win_diff[ffwrl_pkg::NOW_W]
                     && (win_diff[ffwrl_pkg::NOW_W-1:0] >= {7'b0, cfg.window_seconds});
   assign restart  = (entry_cur.start == '0) || expired;
   assign count_eff = restart ? '0 : entry_cur.count;
   assign limited  = (cfg.max_per_window != '0) && (count_eff >= cfg.max_per_window);

   always_comb begin
      tbl_we          = 1'b0;
      entry_new.start = restart ? s1_now_ff : entry_cur.start;
      entry_new.count = count_eff;
      if (!limited && (count_eff != ffwrl_pkg::COUNT_MAX)) begin
         entry_new.count = count_eff + ffwrl_pkg::COUNT_W'(1);
      end
      if (!cfg.enable) begin
         verdict_in = ffwrl_pkg::VERDICT_DISABLED;
      end else if (s1_state_ff) begin
         verdict_in = ffwrl_pkg::VERDICT_STATE;
      end else if (cfg.skip_automated && s1_auto_ff) begin
         verdict_in = ffwrl_pkg::VERDICT_AUTO;
      end else if ((cfg.age_limit != '0) && (undated || too_old)) begin
         verdict_in = ffwrl_pkg::VERDICT_AGE;
      end else begin
         tbl_we     = s1_valid_ff;
         verdict_in = limited ? ffwrl_pkg::VERDICT_RATE : ffwrl_pkg::VERDICT_ADMITTED;
      end
   end

   assign fwd_valid_in = tbl_we;

   always_ff @(posedge clock) begin
      if (reset) begin
         fwd_valid_ff <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         fwd_valid_ff <= fwd_valid_in;
         rsp_valid_ff <= s1_valid_ff;
      end
      fwd_idx_ff      <= s1_idx_ff;
      fwd_entry_ff    <= entry_new;
      rsp_verdict_ff  <= verdict_in;
      rsp_admitted_ff <= (verdict_in == ffwrl_pkg::VERDICT_ADMITTED);
   end

   assign rsp_valid    = rsp_valid_ff;
   assign rsp_admitted = rsp_admitted_ff;
   assign rsp_verdict  = rsp_verdict_ff;

endmodule
